// ===== design/srt_pkg.sv =====
// Shared types and constants for the slot reservation table.
// Used by srt_ctrl, srt_datapath and slot_reservation_table_top; no dependencies.
package srt_pkg;

    // Table geometry
    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Fixed field widths
    localparam int TIME_W = 16;
    localparam int OP_W   = 3;
    localparam int HIT_W  = 4;
    localparam int FILL_W = 5;
    localparam int CODE_W = 2;

    // One stored slot record
    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] finish;
        logic [TIME_W-1:0] longest;
        logic [TIME_W-1:0] shortest;
        logic              booked;
    } t_slot_rec;

    // Operation codes of the input word
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_BOOK   = 3'd1,
        OP_CANCEL = 3'd2,
        OP_SORT   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    // Result codes of the output word
    typedef enum logic [CODE_W-1:0] {
        RES_DONE = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } t_res_code;

    // Datapath action issued by the controller each cycle
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_LOAD,
        ACT_IDX_INC,
        ACT_MARK,
        ACT_CARRY,
        ACT_SORT_STEP,
        ACT_SORT_TAIL,
        ACT_SORT_OK,
        ACT_READ_DONE,
        ACT_PUBLISH
    } t_dp_act;

    // Table read address source
    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_ENTRY
    } t_rd_sel;

    typedef struct packed {
        t_dp_act act;
        logic    rd_en;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_end;
        logic            match;
        logic            pair_end;
        logic            pass_last;
        logic            sort_small;
        logic            read_ok;
        logic            out_busy;
    } t_dp_stat;

endpackage

// ===== design/slot_reservation_table_top.sv =====
// Slot reservation table, one word at a time. Load writes one slot or reports full; read fetches
// one slot (a miss beyond the count or on an unused code); book/cancel read the slots one by one
// until a match, else a miss; sort compares neighbouring slots through one RAM read port,
// one compare step at a time, over the filled part of the table.
// Next word accepted once the result sits in the output register. Synchronous active-low
// reset clears the slot count and control state; slot contents stay undefined until loaded.
module slot_reservation_table_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [srt_pkg::OP_W-1:0]     i_operation,
    input  logic [srt_pkg::TIME_W-1:0]   i_key_time,
    input  logic [srt_pkg::TIME_W-1:0]   i_slot_finish,
    input  logic [srt_pkg::TIME_W-1:0]   i_longest,
    input  logic [srt_pkg::TIME_W-1:0]   i_shortest,
    input  logic                         i_restart,
    input  logic [srt_pkg::HIT_W-1:0]    i_entry_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [srt_pkg::CODE_W-1:0]   o_result_code,
    output logic [srt_pkg::HIT_W-1:0]    o_hit_index,
    output logic [srt_pkg::TIME_W-1:0]   o_out_start,
    output logic [srt_pkg::TIME_W-1:0]   o_out_finish,
    output logic [srt_pkg::TIME_W-1:0]   o_out_longest,
    output logic [srt_pkg::TIME_W-1:0]   o_out_shortest,
    output logic                         o_out_booked,
    output logic [srt_pkg::FILL_W-1:0]   o_filled
);

    srt_pkg::t_dp_cmd  w_cmd;
    srt_pkg::t_dp_stat w_stat;

    // Sequence each operation
    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Hold the table and the result
    srt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_operation    (i_operation),
        .i_key_time     (i_key_time),
        .i_slot_finish  (i_slot_finish),
        .i_longest      (i_longest),
        .i_shortest     (i_shortest),
        .i_restart      (i_restart),
        .i_entry_index  (i_entry_index),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_code  (o_result_code),
        .o_hit_index    (o_hit_index),
        .o_out_start    (o_out_start),
        .o_out_finish   (o_out_finish),
        .o_out_longest  (o_out_longest),
        .o_out_shortest (o_out_shortest),
        .o_out_booked   (o_out_booked),
        .o_filled       (o_filled)
    );

endmodule

// ===== design/srt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/srt_ctrl.sv =====
// Controller state machine for the slot reservation table.
// Depends on srt_pkg; drives srt_datapath through t_dp_cmd and reads t_dp_stat.
module srt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  srt_pkg::t_dp_stat i_stat,
    output srt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SORT_RD0,
        S_SORT_LD,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_TAIL,
        S_READ_RD,
        S_READ_DATA,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Pick next state and the datapath command
    always_comb begin
        n_state      = r_state;
        o_cmd.act    = srt_pkg::ACT_NONE;
        o_cmd.rd_en  = 1'b0;
        o_cmd.rd_sel = srt_pkg::RD_IDX;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.act = srt_pkg::ACT_CAPTURE;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    srt_pkg::OP_LOAD: n_state = S_LOAD;
                    srt_pkg::OP_BOOK,
                    srt_pkg::OP_CANCEL: n_state = S_SCAN_RD;
                    srt_pkg::OP_SORT: begin
                        if (i_stat.sort_small) begin
                            o_cmd.act = srt_pkg::ACT_SORT_OK;
                            n_state   = S_FINISH;
                        end else begin
                            n_state = S_SORT_RD0;
                        end
                    end
                    srt_pkg::OP_READ: begin
                        n_state = i_stat.read_ok ? S_READ_RD : S_FINISH;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_LOAD: begin
                o_cmd.act = srt_pkg::ACT_LOAD;
                n_state   = S_FINISH;
            end
            S_SCAN_RD: begin
                if (i_stat.idx_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.match) begin
                    o_cmd.act = srt_pkg::ACT_MARK;
                    n_state   = S_FINISH;
                end else begin
                    o_cmd.act = srt_pkg::ACT_IDX_INC;
                    n_state   = S_SCAN_RD;
                end
            end
            S_SORT_RD0: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SORT_LD;
            end
            S_SORT_LD: begin
                o_cmd.act    = srt_pkg::ACT_CARRY;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = srt_pkg::RD_NEXT;
                n_state      = S_SORT_CMP;
            end
            S_SORT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = srt_pkg::RD_NEXT;
                n_state      = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                o_cmd.act = srt_pkg::ACT_SORT_STEP;
                n_state   = i_stat.pair_end ? S_SORT_TAIL : S_SORT_RD;
            end
            S_SORT_TAIL: begin
                o_cmd.act = srt_pkg::ACT_SORT_TAIL;
                n_state   = i_stat.pass_last ? S_FINISH : S_SORT_RD0;
            end
            S_READ_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = srt_pkg::RD_ENTRY;
                n_state      = S_READ_DATA;
            end
            S_READ_DATA: begin
                o_cmd.act = srt_pkg::ACT_READ_DONE;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.act = srt_pkg::ACT_PUBLISH;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/srt_datapath.sv =====
// Datapath of the slot reservation table: slot RAM, count, scan and sort
// registers, pending result and output register. Depends on srt_pkg, srt_ram.
module srt_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srt_pkg::t_dp_cmd             i_cmd,
    output srt_pkg::t_dp_stat            o_stat,
    input  logic [srt_pkg::OP_W-1:0]     i_operation,
    input  logic [srt_pkg::TIME_W-1:0]   i_key_time,
    input  logic [srt_pkg::TIME_W-1:0]   i_slot_finish,
    input  logic [srt_pkg::TIME_W-1:0]   i_longest,
    input  logic [srt_pkg::TIME_W-1:0]   i_shortest,
    input  logic                         i_restart,
    input  logic [srt_pkg::HIT_W-1:0]    i_entry_index,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [srt_pkg::CODE_W-1:0]   o_result_code,
    output logic [srt_pkg::HIT_W-1:0]    o_hit_index,
    output logic [srt_pkg::TIME_W-1:0]   o_out_start,
    output logic [srt_pkg::TIME_W-1:0]   o_out_finish,
    output logic [srt_pkg::TIME_W-1:0]   o_out_longest,
    output logic [srt_pkg::TIME_W-1:0]   o_out_shortest,
    output logic                         o_out_booked,
    output logic [srt_pkg::FILL_W-1:0]   o_filled
);

    localparam int CNT_W = srt_pkg::CNT_W;
    localparam int IDX_W = srt_pkg::IDX_W;

    // Captured input word
    logic [srt_pkg::OP_W-1:0]   r_op;
    logic [srt_pkg::TIME_W-1:0] r_key;
    logic [srt_pkg::TIME_W-1:0] r_fin;
    logic [srt_pkg::TIME_W-1:0] r_lng;
    logic [srt_pkg::TIME_W-1:0] r_sht;
    logic                       r_restart;
    logic [srt_pkg::HIT_W-1:0]  r_entry;

    // Table control
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_idx;
    logic [CNT_W-1:0]           r_pass;
    srt_pkg::t_slot_rec         r_carry;

    // Pending result
    srt_pkg::t_res_code         r_res_code;
    logic [srt_pkg::HIT_W-1:0]  r_res_hit;
    srt_pkg::t_slot_rec         r_res_rec;

    // Output register
    logic                       r_out_valid;
    srt_pkg::t_res_code         r_out_code;
    logic [srt_pkg::HIT_W-1:0]  r_out_hit;
    srt_pkg::t_slot_rec         r_out_rec;
    logic [srt_pkg::FILL_W-1:0] r_out_filled;

    // RAM ports
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    srt_pkg::t_slot_rec         w_wdata;
    logic [IDX_W-1:0]           w_raddr;
    srt_pkg::t_slot_rec         w_rdata;

    logic [CNT_W-1:0]           w_base;
    logic                       w_full;
    logic [CNT_W-1:0]           w_idx_next;
    logic [CNT_W:0]             w_idx_plus2;
    logic [CNT_W:0]             w_pass_next;
    logic                       w_swap;
    srt_pkg::t_slot_rec         w_load_rec;
    srt_pkg::t_slot_rec         w_mark_rec;

    srt_ram #(
        .WIDTH ($bits(srt_pkg::t_slot_rec)),
        .DEPTH (srt_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Derive load position, scan and sort indexes
    assign w_base      = r_restart ? '0 : r_count;
    assign w_full      = (w_base >= CNT_W'(srt_pkg::SLOTS));
    assign w_idx_next  = r_idx + CNT_W'(1);
    assign w_idx_plus2 = {1'b0, r_idx} + (CNT_W+1)'(2);
    assign w_pass_next = {1'b0, r_pass} + (CNT_W+1)'(1);
    assign w_swap      = (r_carry.start > w_rdata.start);

    always_comb begin
        w_load_rec          = '0;
        w_load_rec.start    = r_key;
        w_load_rec.finish   = r_fin;
        w_load_rec.longest  = r_lng;
        w_load_rec.shortest = r_sht;
        w_mark_rec          = w_rdata;
        w_mark_rec.booked   = (r_op == srt_pkg::OP_BOOK);
    end

    // Select read address
    always_comb begin
        case (i_cmd.rd_sel)
            srt_pkg::RD_IDX:   w_raddr = r_idx[IDX_W-1:0];
            srt_pkg::RD_NEXT:  w_raddr = w_idx_next[IDX_W-1:0];
            srt_pkg::RD_ENTRY: w_raddr = r_entry[IDX_W-1:0];
            default:           w_raddr = r_idx[IDX_W-1:0];
        endcase
    end

    // Select write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IDX_W-1:0];
        w_wdata = r_carry;
        case (i_cmd.act)
            srt_pkg::ACT_LOAD: begin
                w_we    = !w_full;
                w_waddr = w_base[IDX_W-1:0];
                w_wdata = w_load_rec;
            end
            srt_pkg::ACT_MARK: begin
                w_we    = 1'b1;
                w_wdata = w_mark_rec;
            end
            srt_pkg::ACT_SORT_STEP: begin
                w_we    = 1'b1;
                w_wdata = w_swap ? w_rdata : r_carry;
            end
            srt_pkg::ACT_SORT_TAIL: begin
                w_we    = 1'b1;
                w_wdata = r_carry;
            end
            default: w_we = 1'b0;
        endcase
    end

    // Report status to the controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.idx_end    = (r_idx >= r_count);
        o_stat.match      = (w_rdata.start == r_key)
                            && (w_rdata.booked == (r_op == srt_pkg::OP_CANCEL));
        o_stat.pair_end   = (w_idx_plus2 >= {1'b0, r_count});
        o_stat.pass_last  = (w_pass_next >= {1'b0, r_count});
        o_stat.sort_small = (r_count < CNT_W'(2));
        o_stat.read_ok    = (CNT_W'(r_entry) < r_count);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    // Control registers: count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.act == srt_pkg::ACT_LOAD && !w_full) begin
                r_count <= w_base + CNT_W'(1);
            end
            if (i_cmd.act == srt_pkg::ACT_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture, scan, sort, pending result, output word
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            srt_pkg::ACT_CAPTURE: begin
                r_op       <= i_operation;
                r_key      <= i_key_time;
                r_fin      <= i_slot_finish;
                r_lng      <= i_longest;
                r_sht      <= i_shortest;
                r_restart  <= i_restart;
                r_entry    <= i_entry_index;
                r_idx      <= '0;
                r_pass     <= CNT_W'(1);
                r_res_code <= srt_pkg::RES_MISS;
                r_res_hit  <= '0;
                r_res_rec  <= '0;
            end
            srt_pkg::ACT_LOAD: begin
                if (w_full) begin
                    r_res_code <= srt_pkg::RES_FULL;
                end else begin
                    r_res_code <= srt_pkg::RES_DONE;
                    r_res_hit  <= w_base[srt_pkg::HIT_W-1:0];
                end
            end
            srt_pkg::ACT_IDX_INC: begin
                r_idx <= w_idx_next;
            end
            srt_pkg::ACT_MARK: begin
                r_res_code <= srt_pkg::RES_DONE;
                r_res_hit  <= r_idx[srt_pkg::HIT_W-1:0];
            end
            srt_pkg::ACT_CARRY: begin
                r_carry <= w_rdata;
            end
            srt_pkg::ACT_SORT_STEP: begin
                if (!w_swap) begin
                    r_carry <= w_rdata;
                end
                r_idx <= w_idx_next;
            end
            srt_pkg::ACT_SORT_TAIL: begin
                r_idx  <= '0;
                r_pass <= w_pass_next[CNT_W-1:0];
                if (w_pass_next >= {1'b0, r_count}) begin
                    r_res_code <= srt_pkg::RES_DONE;
                end
            end
            srt_pkg::ACT_SORT_OK: begin
                r_res_code <= srt_pkg::RES_DONE;
            end
            srt_pkg::ACT_READ_DONE: begin
                r_res_code <= srt_pkg::RES_DONE;
                r_res_hit  <= r_entry;
                r_res_rec  <= w_rdata;
            end
            srt_pkg::ACT_PUBLISH: begin
                r_out_code   <= r_res_code;
                r_out_hit    <= r_res_hit;
                r_out_rec    <= r_res_rec;
                r_out_filled <= srt_pkg::FILL_W'(r_count);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_code  = r_out_code;
    assign o_hit_index    = r_out_hit;
    assign o_out_start    = r_out_rec.start;
    assign o_out_finish   = r_out_rec.finish;
    assign o_out_longest  = r_out_rec.longest;
    assign o_out_shortest = r_out_rec.shortest;
    assign o_out_booked   = r_out_rec.booked;
    assign o_filled       = r_out_filled;

    // Table never holds more than its capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(srt_pkg::SLOTS))
        else $error("slot count exceeds capacity");

    // A result is never published over one that is still waiting
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act == srt_pkg::ACT_PUBLISH |-> !(r_out_valid && !i_out_ready))
        else $error("result published over a waiting word");

    // Sort compare steps stay on pairs inside the filled part of the table
    a_sort_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act == srt_pkg::ACT_SORT_STEP |-> w_idx_next < r_count)
        else $error("sort step beyond last filled slot");

    // Publishing raises the output valid on the next edge
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act == srt_pkg::ACT_PUBLISH |=> r_out_valid)
        else $error("published result not presented");

endmodule
